/* rtl/sstv_pixel_to_tone_defines.svh */
// Assertion macros for the pixel-to-tone converter.
// Used by rtl/sstv_pixel_to_tone.sv; expects clk and rst in scope.
`ifndef SSTV_PIXEL_TO_TONE_DEFINES_SVH
`define SSTV_PIXEL_TO_TONE_DEFINES_SVH
`ifndef SYNTHESIS
`define SSTV_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sstv_pixel_to_tone: invariant violated");
`define SSTV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sstv_pixel_to_tone: implication violated");
`else
`define SSTV_ASSERT(label, cond)
`define SSTV_ASSERT_IMPL(label, ante, cons)
`endif
`endif

/* rtl/sstv_p2t_pkg.sv */
// Constants, codes and coefficient table for the pixel-to-tone converter.
// No dependencies; imported by rtl/sstv_pixel_to_tone.sv.
package sstv_p2t_pkg;

  localparam int PosBitsDefault = 11;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] RegScanMode      = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPatternEnable = 2'd1;

  localparam logic [1:0] ModeMono = 2'd0;
  localparam logic [1:0] ModeRgb  = 2'd1;
  localparam logic [1:0] ModeYcc  = 2'd2;
  localparam logic [1:0] ScanModeReset = ModeYcc;

  localparam logic [1:0] PassFirst  = 2'd0;
  localparam logic [1:0] PassSecond = 2'd1;
  localparam logic [1:0] PassThird  = 2'd2;

  localparam logic [7:0] LevelFull = 8'd255;
  localparam logic [7:0] LevelZero = 8'd0;

  // Every law is folded into floor(X / DivD) with X < 2^XW.
  localparam int XW    = 42;
  localparam int SumW  = XW + 2;
  localparam int CoefW = 36;
  localparam int DW    = 25;
  localparam int QW    = 18;
  localparam int RemW  = 27;
  localparam int ToneW = 20;

  localparam longint DivVal = 64'sd51 * 64'sd390625;
  localparam logic [DW-1:0] DivD = DW'(DivVal);
  localparam logic [QW-1:0] RecipM = QW'((64'sd1 <<< XW) / DivVal);
  localparam logic [RemW-1:0] DivOne   = RemW'(DivVal);
  localparam logic [RemW-1:0] DivTwo   = RemW'(64'sd2 * DivVal);
  localparam logic [RemW-1:0] DivThree = RemW'(64'sd3 * DivVal);

  localparam logic [ToneW-1:0] BaseQ8    = 20'd384000;
  localparam logic [ToneW-1:0] ToneMaxQ8 = 20'd589824;

  // monochrome: (s*2048 + 127) / 255, scaled by 78125
  localparam longint MonoScale = 64'sd2048 * 64'sd78125;
  localparam longint MonoOff   = 64'sd127 * 64'sd78125;
  // direct channel: (c*40960 + 25) / 51, scaled by 390625
  localparam longint RgbCoef = 64'sd40960 * 64'sd390625;
  localparam longint RgbOff  = 64'sd25 * 64'sd390625;
  // matrix: X = 32*(K*5e8 + 1953*S) + 9960937
  localparam longint MatScale = 64'sd32 * 64'sd1953;
  localparam longint MatRound = 64'sd9960937;
  localparam longint MatOffY  = 64'sd32 * 64'sd16 * 64'sd500000000 + MatRound;
  localparam longint MatOffC  = 64'sd32 * 64'sd128 * 64'sd500000000 + MatRound;

  typedef struct packed {
    logic signed [CoefW-1:0] cr;
    logic signed [CoefW-1:0] cg;
    logic signed [CoefW-1:0] cb;
    logic [XW-1:0]           off;
  } coef_t;

  function automatic coef_t coef_sel(input logic [1:0] mode, input logic [1:0] pass);
    coef_t c;
    c = '0;
    case (mode)
      ModeMono: begin
        c.cr  = CoefW'(64'sd30 * MonoScale);
        c.cg  = CoefW'(64'sd59 * MonoScale);
        c.cb  = CoefW'(64'sd11 * MonoScale);
        c.off = XW'(MonoOff);
      end
      ModeRgb: begin
        c.off = XW'(RgbOff);
        case (pass)
          PassFirst:  c.cr = CoefW'(RgbCoef);
          PassSecond: c.cg = CoefW'(RgbCoef);
          default:    c.cb = CoefW'(RgbCoef);
        endcase
      end
      default: begin
        case (pass)
          PassFirst: begin
            c.cr  = CoefW'(64'sd65738 * MatScale);
            c.cg  = CoefW'(64'sd129057 * MatScale);
            c.cb  = CoefW'(64'sd25064 * MatScale);
            c.off = XW'(MatOffY);
          end
          PassSecond: begin
            c.cr  = CoefW'(64'sd112439 * MatScale);
            c.cg  = CoefW'(-64'sd94154 * MatScale);
            c.cb  = CoefW'(-64'sd18285 * MatScale);
            c.off = XW'(MatOffC);
          end
          default: begin
            c.cr  = CoefW'(-64'sd37945 * MatScale);
            c.cg  = CoefW'(-64'sd74494 * MatScale);
            c.cb  = CoefW'(64'sd112439 * MatScale);
            c.off = XW'(MatOffC);
          end
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

/* rtl/sstv_pixel_to_tone.sv */
// Pixel-to-tone converter: six register stages, one beat in and one beat out per cycle.
// Throughput: 1 item per cycle while out_ready stays high, else the flow backs up.
// Stages: pattern test, channel products, sum, reciprocal estimate, remainder, correction.
// A stall at the output backs up only as far as the first empty stage.
// Reset (rst, synchronous) empties the pipeline and sets scan_mode = 2, pattern_enable = 0.
// Depends on sstv_p2t_pkg and sstv_pixel_to_tone_defines.svh.
`include "sstv_pixel_to_tone_defines.svh"

module sstv_pixel_to_tone
  import sstv_p2t_pkg::*;
#(
  parameter int POS_BITS = PosBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           pass_index,
  input  logic [POS_BITS-1:0]  x_position,
  input  logic [POS_BITS-1:0]  y_position,
  input  logic                 pixel_valid,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ToneW-1:0]     tone_hz_q8
);

  localparam int PosSumW  = POS_BITS + 1;
  localparam int PatK     = PosSumW + 4;
  localparam int PatProdW = PosSumW + PatK;
  // floor(n / 11) = (n * PatMul) >> PatK for every n below 2^PosSumW
  localparam logic [PatK-1:0] PatMul = PatK'(((64'd1 << PatK) + 64'd10) / 64'd11);

  // configuration registers
  logic [1:0] scan_mode;
  logic       pattern_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= ScanModeReset;
      pattern_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegScanMode:      scan_mode      <= cfg_data[1:0];
        RegPatternEnable: pattern_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  assign adv6     = !out_valid || out_ready;
  assign adv5     = !v5 || adv6;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
      if (adv6) out_valid <= v5;
    end
  end

  // stage 1: clamp pass and mode, test the diagonal pattern
  logic [PosSumW-1:0]  pos_sum;
  logic [PatProdW-1:0] pos_prod;
  logic [1:0]          pass_next;
  logic [1:0]          mode_next;
  logic                pat_next;

  assign pos_sum   = PosSumW'(x_position) + PosSumW'(y_position);
  assign pos_prod  = PatProdW'(pos_sum) * PatProdW'(PatMul);
  assign pat_next  = pattern_enable && pos_prod[PatK];
  assign pass_next = (pass_index > PassThird) ? PassThird : pass_index;
  assign mode_next = (scan_mode > ModeYcc) ? ModeYcc : scan_mode;

  logic [1:0] pass1, mode1;
  logic       pat1, pixv1;
  logic [7:0] r1, g1, b1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      pass1 <= pass_next;
      mode1 <= mode_next;
      pat1  <= pat_next;
      pixv1 <= pixel_valid;
      r1    <= red;
      g1    <= green;
      b1    <= blue;
    end
  end

  // stage 2: letterbox color, then one product per channel
  logic [7:0] ch_r, ch_g, ch_b;
  coef_t      coef;
  logic signed [SumW-1:0] p_r_next, p_g_next, p_b_next;

  // yellow on the pattern (white in monochrome mode), black elsewhere
  assign ch_r = pixv1 ? r1 : (pat1 ? LevelFull : LevelZero);
  assign ch_g = pixv1 ? g1 : (pat1 ? LevelFull : LevelZero);
  assign ch_b = pixv1 ? b1 : ((pat1 && mode1 == ModeMono) ? LevelFull : LevelZero);
  assign coef = coef_sel(mode1, pass1);

  assign p_r_next = $signed(SumW'(ch_r)) * SumW'(coef.cr);
  assign p_g_next = $signed(SumW'(ch_g)) * SumW'(coef.cg);
  assign p_b_next = $signed(SumW'(ch_b)) * SumW'(coef.cb);

  logic signed [SumW-1:0] p_r2, p_g2, p_b2;
  logic [XW-1:0]          off2;

  always_ff @(posedge clk) begin
    if (adv2) begin
      p_r2 <= p_r_next;
      p_g2 <= p_g_next;
      p_b2 <= p_b_next;
      off2 <= coef.off;
    end
  end

  // stage 3: dividend X
  logic signed [SumW-1:0] x_next;
  logic [SumW-1:0]        x3;

  assign x_next = p_r2 + p_g2 + p_b2 + $signed(SumW'(off2));

  always_ff @(posedge clk) begin
    if (adv3) x3 <= x_next;
  end

  // stage 4: quotient estimate from the top bits, short by at most two
  logic [XW-1:0] est_prod;

  assign est_prod = XW'(x3[XW-1:QW]) * XW'(RecipM);

  logic [QW-1:0] q4;
  logic [XW-1:0] x4;

  always_ff @(posedge clk) begin
    if (adv4) begin
      q4 <= est_prod[XW-1:XW-QW];
      x4 <= x3[XW-1:0];
    end
  end

  // stage 5: remainder against the estimate
  logic [XW-1:0] qd;
  logic [XW-1:0] rem_full;

  assign qd       = XW'(q4) * XW'(DivD);
  assign rem_full = x4 - qd;

  logic [QW-1:0]   q5;
  logic [RemW-1:0] rem5;

  always_ff @(posedge clk) begin
    if (adv5) begin
      q5   <= q4;
      rem5 <= rem_full[RemW-1:0];
    end
  end

  // stage 6: correct the estimate, add the 1500 Hz base
  logic [QW-1:0]    q_fix;
  logic [ToneW-1:0] tone_next;

  assign q_fix     = q5 + QW'(rem5 >= DivOne) + QW'(rem5 >= DivTwo);
  assign tone_next = BaseQ8 + ToneW'(q_fix);

  always_ff @(posedge clk) begin
    if (adv6) tone_hz_q8 <= tone_next;
  end

  `SSTV_ASSERT_IMPL(a_dividend_range, v3, x3[SumW-1:XW] == '0)
  `SSTV_ASSERT_IMPL(a_estimate_close, v5, rem5 < DivThree)
  `SSTV_ASSERT_IMPL(a_tone_range, out_valid, tone_hz_q8 >= BaseQ8 && tone_hz_q8 <= ToneMaxQ8)

endmodule

/* verif/tb_sstv_pixel_to_tone.sv */
// Self-checking testbench for sstv_pixel_to_tone: directed pixels, then random pixels under
// every scan mode and pattern setting, with random idling and one long output stall.
// Depends on rtl/sstv_p2t_pkg.sv and the RTL of sstv_pixel_to_tone.
module tb_sstv_pixel_to_tone;
  import sstv_p2t_pkg::*;

  localparam int PosBits = PosBitsDefault;
  localparam logic [ToneW-1:0] ToneTopQ8 = 20'd588800;
  localparam int RstCycles = 12;
  localparam int SettleCycles = 12;
  localparam int StallCycles = 400;
  localparam int StallPhase = 9;
  localparam int NumPhases = 12;
  localparam int PixelsPerPhase = 150;
  localparam int IdleLimit = 5000;
  localparam int MaxPrinted = 40;

  class ToneScoreboard;
    logic [1:0] scan_mode;
    logic pattern_on;
    logic [ToneW-1:0] expected_tones[$];
    int errors;

    function new();
      scan_mode = ScanModeReset;
      pattern_on = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == RegScanMode) begin
        scan_mode = data[1:0];
      end else if (idx == RegPatternEnable) begin
        pattern_on = data[0];
      end
    endfunction

    function logic [ToneW-1:0] predict_tone(logic [1:0] pass_in, logic [PosBits-1:0] x,
                                            logic [PosBits-1:0] y, logic pv,
                                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [1:0] chan;
      logic [1:0] mode;
      logic on_pat;
      longint pos_sum;
      longint rr, gg, bb, c, s, k, n;
      logic [ToneW-1:0] tone;
      chan = (pass_in > PassThird) ? PassThird : pass_in;
      mode = (scan_mode > ModeYcc) ? ModeYcc : scan_mode;
      pos_sum = longint'(x) + longint'(y);
      on_pat = pattern_on && (((pos_sum / 11) % 2) == 1);
      rr = longint'(r);
      gg = longint'(g);
      bb = longint'(b);
      case (mode)
        ModeMono: begin
          if (pv) begin
            s = 30 * rr + 59 * gg + 11 * bb;
            tone = BaseQ8 + ToneW'((s * 2048 + 127) / 255);
          end else begin
            tone = on_pat ? ToneTopQ8 : BaseQ8;
          end
        end
        ModeRgb: begin
          if (pv) begin
            c = (chan == PassFirst) ? rr : ((chan == PassSecond) ? gg : bb);
            tone = BaseQ8 + ToneW'((c * 40960 + 25) / 51);
          end else begin
            tone = (on_pat && chan != PassThird) ? ToneTopQ8 : BaseQ8;
          end
        end
        default: begin
          // letterbox slot: yellow on the pattern, black elsewhere
          if (!pv) begin
            rr = on_pat ? 255 : 0;
            gg = on_pat ? 255 : 0;
            bb = 0;
          end
          case (chan)
            PassFirst: begin
              k = 16;
              s = 65738 * rr + 129057 * gg + 25064 * bb;
            end
            PassSecond: begin
              k = 128;
              s = 112439 * rr - 94154 * gg - 18285 * bb;
            end
            default: begin
              k = 128;
              s = -37945 * rr - 74494 * gg + 112439 * bb;
            end
          endcase
          n = k * 1000000000 + 3906 * s;
          if (n < 0) n = 0;
          tone = BaseQ8 + ToneW'((n * 1024 + 637500000) / 1275000000);
        end
      endcase
      return tone;
    endfunction

    function void note_pixel(logic [1:0] pass_in, logic [PosBits-1:0] x,
                             logic [PosBits-1:0] y, logic pv,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
      expected_tones = {expected_tones, predict_tone(pass_in, x, y, pv, r, g, b)};
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_tone(logic [ToneW-1:0] got);
      logic [ToneW-1:0] want;
      if (expected_tones.size() == 0) begin
        report($sformatf("unexpected tone beat %0d", got));
      end else begin
        want = expected_tones.pop_front();
        if (got !== want) report($sformatf("tone_hz_q8 got %0d expected %0d", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] pass_index;
  logic [PosBits-1:0] x_position;
  logic [PosBits-1:0] y_position;
  logic pixel_valid;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic out_valid;
  logic out_ready;
  logic [ToneW-1:0] tone_hz_q8;

  ToneScoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  logic stall_go;
  int quiet_cycles;

  sstv_pixel_to_tone #(.POS_BITS(PosBits)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pass_index(pass_index),
    .x_position(x_position),
    .y_position(y_position),
    .pixel_valid(pixel_valid),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tone_hz_q8(tone_hz_q8)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample every handshake on pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) sb.check_tone(tone_hz_q8);
      if (in_valid && in_ready) begin
        sb.note_pixel(pass_index, x_position, y_position, pixel_valid, red, green, blue);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random backpressure plus one long hold-off to fill the pipeline.
  initial begin : receiver
    bit stall_done;
    stall_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_go && !stall_done) begin
        out_ready <= 1'b0;
        stall_done = 1'b1;
        repeat (StallCycles) @(posedge clk);
      end else if (rst) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic program_regs(logic [CfgDataW-1:0] mode_data, logic [CfgDataW-1:0] pat_data);
    cfg_valid <= 1'b1;
    cfg_index <= RegScanMode;
    cfg_data <= mode_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= RegPatternEnable;
    cfg_data <= pat_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [1:0] p, logic [PosBits-1:0] x, logic [PosBits-1:0] y,
                            logic pv, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pass_index <= p;
    x_position <= x;
    y_position <= y;
    pixel_valid <= pv;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold input idle until every tone has come back, then let the pipeline settle.
  task automatic drain_tones();
    in_valid <= 1'b0;
    while (sb.expected_tones.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_level();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return LevelZero;
    if (pick == 1) return LevelFull;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_directed();
    send_pixel(PassFirst, 11'd0, 11'd0, 1'b1, LevelZero, LevelZero, LevelZero);
    send_pixel(PassSecond, 11'd2047, 11'd2047, 1'b1, LevelFull, LevelFull, LevelFull);
    send_pixel(PassThird, 11'd1024, 11'd5, 1'b1, LevelFull, LevelZero, LevelFull);
    // pass above the third clamps to the third
    send_pixel(2'd3, 11'd3, 11'd7, 1'b1, LevelZero, LevelFull, LevelZero);
    // letterbox slot on the diagonal pattern
    send_pixel(PassFirst, 11'd11, 11'd0, 1'b0, 8'd170, 8'd85, 8'd51);
    send_pixel(2'd3, 11'd2047, 11'd12, 1'b0, 8'd85, 8'd170, 8'd204);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    logic [1:0] mode_sel;
    logic pat_sel;
    sb = new();
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= RegScanMode;
    cfg_data <= '0;
    in_valid <= 1'b0;
    pass_index <= PassFirst;
    x_position <= '0;
    y_position <= '0;
    pixel_valid <= 1'b0;
    red <= LevelZero;
    green <= LevelZero;
    blue <= LevelZero;
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    stall_go <= 1'b0;
    repeat (RstCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings first, then mono, rgb, and mode three with a wide enable
    send_directed();
    drain_tones();
    program_regs(ModeMono, 2'b01);
    send_directed();
    drain_tones();
    program_regs(ModeRgb, 2'b01);
    send_directed();
    drain_tones();
    program_regs(2'b11, 2'b11);
    send_directed();
    drain_tones();

    for (phase = 0; phase < NumPhases; phase++) begin
      mode_sel = 2'(phase % 4);
      pat_sel = 1'((phase + phase / 4) % 2);
      program_regs(mode_sel, {1'($urandom_range(1)), pat_sel});
      if (phase < 4) begin
        send_idle_pct <= 6;
        recv_idle_pct <= 73;
      end else if (phase < 8) begin
        send_idle_pct <= 73;
        recv_idle_pct <= 6;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (phase == StallPhase) stall_go <= 1'b1;
      for (n = 0; n < PixelsPerPhase; n++) begin
        send_pixel(2'($urandom_range(3)), PosBits'($urandom_range(2047)),
                   PosBits'($urandom_range(2047)), ($urandom_range(99) < 75),
                   rand_level(), rand_level(), rand_level());
      end
      drain_tones();
    end

    if (sb.expected_tones.size() != 0) begin
      sb.report($sformatf("%0d tones never arrived", sb.expected_tones.size()));
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
